// File: hw/rtl/cmd_pkg.sv
// ----------------------------------------------------------------------------
// cmd_pkg
// Shared types and constants for the controller message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmd_pkg;

    localparam int MAX_TEXT = 256;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_DOT = 8'd46;

    localparam logic [1:0] MODE_RESPONSE = 2'd1;
    localparam logic [1:0] MODE_REMOTE   = 2'd2;

    typedef struct packed {
        logic [1:0] frame_mode;
        logic [7:0] end_first;
        logic [7:0] end_second;
        logic [7:0] begin_mark;
        logic [7:0] ack_terminator;
        logic       show_bad_cr;
        logic [8:0] max_len;
    } cfg_t;

    typedef struct packed {
        logic       write_valid;
        logic [8:0] write_index;
        logic [7:0] write_byte;
        logic       last_of_run;
        logic       message_done;
        logic       dropped;
        logic [8:0] text_length;
    } result_t;

    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } result_set_t;

endpackage

`default_nettype wire

// File: hw/rtl/cmd_step.sv
// ----------------------------------------------------------------------------
// cmd_step
// Input register, framing state and the per-byte step logic producing up to
// three buffer writes for each received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_step
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_pkg::cfg_t       cfg,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // data_byte
    input  wire logic                s_axis_tuser,   // new_message
    input  wire logic                can_load,
    output logic                     load,
    output cmd_pkg::result_set_t     res_set
);
    import cmd_pkg::*;

    typedef enum logic [7:0] {
        PH_MSG      = 8'b0000_0001,
        PH_END2     = 8'b0000_0010,
        PH_END1     = 8'b0000_0100,
        PH_ACK      = 8'b0000_1000,
        PH_ACK_END  = 8'b0001_0000,
        PH_ACK_END2 = 8'b0010_0000,
        PH_REMOTE   = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] head0;
        logic [7:0] head1;
        logic [7:0] head2;
        logic [1:0] prefix_progress;
        logic       prefix_ok;
        logic       begin_seen;
        logic       last_is_begin;
        logic       nul_seen;
        logic       last_is_first_nul;
    } track_t;

    function automatic track_t put_track(track_t t, logic [8:0] idx, logic [7:0] b,
                                         logic ovw, logic [7:0] bm);
        track_t r;
        r = t;
        if (idx < 9'd3)
        begin
            case (idx[1:0])
                2'd0:    r.head0 = b;
                2'd1:    r.head1 = b;
                default: r.head2 = b;
            endcase
            if (r.prefix_progress < idx[1:0] + 2'd1)
                r.prefix_progress = idx[1:0] + 2'd1;
        end
        if (ovw)
        begin
            if (r.last_is_first_nul)
                r.nul_seen = 1'b0;
        end
        else if (r.last_is_begin)
        begin
            r.begin_seen = 1'b1;
        end
        r.last_is_begin     = 1'b0;
        r.last_is_first_nul = 1'b0;
        if (!r.nul_seen)
        begin
            if (b == 8'd0)
            begin
                r.nul_seen          = 1'b1;
                r.last_is_first_nul = 1'b1;
            end
            else if (b == bm)
            begin
                r.last_is_begin = 1'b1;
            end
        end
        r.prefix_ok = (r.prefix_progress >= 2'd2 && r.head0 == "o" && r.head1 == "k") ||
                      (r.prefix_progress == 2'd3 && r.head0 == "e" && r.head1 == "r" &&
                       r.head2 == "r");
        return r;
    endfunction

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_new_reg;

    phase_t     phase_reg, phase_next;
    logic [8:0] pos_reg, pos_next;
    track_t     track_reg, track_next;

    phase_t     ph, start_ph;
    logic [8:0] pos, prev;
    track_t     tr, tr_a, tr1;
    logic [9:0] lim;
    logic [7:0] b, want, same;
    phase_t     back;
    logic       drop, force_full, full;
    logic [1:0] n_main, nw;
    logic [8:0] p0_idx, p1_idx;
    logic [7:0] p0_b, p1_b;
    logic       p0_ovw;
    logic [8:0] w_idx [3];
    logic [7:0] w_b   [3];

    assign load          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || can_load;

    always_comb
    begin
        unique case (cfg.frame_mode)
            MODE_RESPONSE: start_ph = PH_ACK;
            MODE_REMOTE:   start_ph = PH_REMOTE;
            default:       start_ph = PH_MSG;
        endcase
    end

    always_comb
    begin
        b   = in_byte_reg;
        ph  = phase_reg;
        pos = pos_reg;
        tr  = track_reg;
        if (in_new_reg)
        begin
            ph  = start_ph;
            pos = '0;
            tr  = '0;
        end

        if (cfg.max_len == 9'd0)
            lim = 10'd1;
        else if ({1'b0, cfg.max_len} > 10'(MAX_TEXT))
            lim = 10'(MAX_TEXT);
        else
            lim = {1'b0, cfg.max_len};

        prev       = (pos != 9'd0) ? pos - 9'd1 : 9'd0;
        tr_a       = put_track(tr, pos, b, 1'b0, cfg.begin_mark);
    end

    always_comb
    begin
        phase_next = ph;
        pos_next   = pos;
        drop       = 1'b1;
        force_full = 1'b0;
        n_main     = 2'd0;
        p0_idx     = pos;
        p0_b       = b;
        p0_ovw     = 1'b0;
        p1_idx     = pos;
        p1_b       = b;
        want       = cfg.end_second;
        same       = cfg.end_first;
        back       = PH_MSG;

        unique case (ph) inside
            PH_MSG:
            begin
                if (b != 8'd0)
                begin
                    if (b == cfg.end_first)
                        phase_next = PH_END2;
                    else if (b == cfg.end_second)
                        phase_next = PH_END1;
                    n_main   = 2'd1;
                    pos_next = pos + 9'd1;
                    drop     = 1'b0;
                end
            end
            PH_END2, PH_END1, PH_ACK_END2:
            begin
                if (ph == PH_ACK_END2)
                begin
                    want = cfg.end_second;
                    same = cfg.end_first;
                    back = PH_ACK_END;
                end
                else if (ph == PH_END2)
                begin
                    want = cfg.end_second;
                    same = cfg.end_first;
                    back = PH_MSG;
                end
                else
                begin
                    want = cfg.end_first;
                    same = cfg.end_second;
                    back = PH_MSG;
                end
                if (ph != PH_ACK_END2 && b == 8'd0)
                begin
                    drop = 1'b1;
                end
                else if (b == want)
                begin
                    n_main   = 2'd1;
                    pos_next = pos + 9'd1;
                    drop     = 1'b0;
                    if (ph == PH_ACK_END2 && !tr_a.prefix_ok && cfg.begin_mark != 8'd0 &&
                        !tr_a.begin_seen && !tr_a.last_is_begin)
                        phase_next = PH_ACK_END;
                    else
                        phase_next = PH_DONE;
                end
                else
                begin
                    if (b != same)
                        phase_next = back;
                    p0_idx = prev;
                    p0_ovw = 1'b1;
                    n_main = 2'd1;
                    if (cfg.show_bad_cr)
                    begin
                        p0_b = CHAR_DOT;
                        if ({1'b0, pos} + 10'd1 >= lim)
                        begin
                            force_full = 1'b1;
                        end
                        else
                        begin
                            n_main   = 2'd2;
                            pos_next = pos + 9'd1;
                            drop     = 1'b0;
                        end
                    end
                    else
                    begin
                        drop = 1'b0;
                    end
                end
            end
            PH_ACK:
            begin
                if (b == cfg.begin_mark)
                    phase_next = PH_ACK_END;
            end
            PH_ACK_END:
            begin
                if (b == cfg.end_first)
                    phase_next = PH_ACK_END2;
                n_main   = 2'd1;
                pos_next = pos + 9'd1;
                drop     = 1'b0;
            end
            PH_REMOTE:
            begin
                if (b == cfg.ack_terminator)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    n_main   = 2'd1;
                    pos_next = pos + 9'd1;
                    drop     = 1'b0;
                end
            end
            default:
            begin
                drop = 1'b1;
            end
        endcase

        tr1        = put_track(tr, p0_idx, p0_b, p0_ovw, cfg.begin_mark);
        track_next = tr;
        if (n_main == 2'd1)
            track_next = tr1;
        else if (n_main == 2'd2)
            track_next = put_track(tr1, p1_idx, p1_b, 1'b0, cfg.begin_mark);

        w_idx[0] = p0_idx;
        w_b[0]   = p0_b;
        w_idx[1] = p1_idx;
        w_b[1]   = p1_b;
        w_idx[2] = '0;
        w_b[2]   = '0;
        nw       = n_main;

        // full buffer: CR LF appended at the current position
        full = (phase_next != PH_DONE) && (force_full || {1'b0, pos_next} >= lim);
        if (full)
        begin
            if (n_main == 2'd0)
            begin
                w_idx[0] = pos_next;
                w_b[0]   = CHAR_CR;
                w_idx[1] = pos_next + 9'd1;
                w_b[1]   = CHAR_LF;
                nw       = 2'd2;
            end
            else
            begin
                w_idx[1] = pos_next;
                w_b[1]   = CHAR_CR;
                w_idx[2] = pos_next + 9'd1;
                w_b[2]   = CHAR_LF;
                nw       = 2'd3;
            end
            pos_next   = pos_next + 9'd2;
            phase_next = PH_DONE;
        end

        res_set.count = (nw == 2'd0) ? 2'd1 : nw;
        for (int i = 0; i < 3; i++)
        begin
            res_set.res[i].write_valid  = (2'(i) < nw);
            res_set.res[i].write_index  = (2'(i) < nw) ? w_idx[i] : 9'd0;
            res_set.res[i].write_byte   = (2'(i) < nw) ? w_b[i] : 8'd0;
            res_set.res[i].last_of_run  = (2'(i) == res_set.count - 2'd1);
            res_set.res[i].message_done = (phase_next == PH_DONE);
            res_set.res[i].dropped      = drop;
            res_set.res[i].text_length  = pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_MSG;
            pos_reg      <= '0;
            track_reg    <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;
            if (load)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                track_reg <= track_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_new_reg  <= s_axis_tuser;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cmd_out.sv
// ----------------------------------------------------------------------------
// cmd_out
// Result register: holds the one to three writes of a byte and hands them
// to the output stream one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_out
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire cmd_pkg::result_set_t res_set,
    output logic                      can_load,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output cmd_pkg::result_t          head_res
);
    import cmd_pkg::*;

    result_t    entry_reg [3];
    logic [1:0] cnt_reg;
    logic       fire;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign fire          = m_axis_tvalid && m_axis_tready;
    assign can_load      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && fire);
    assign head_res      = entry_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= res_set.count;
        else if (fire)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg[0] <= res_set.res[0];
            entry_reg[1] <= res_set.res[1];
            entry_reg[2] <= res_set.res[2];
        end
        else if (fire)
        begin
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/controller_message_deframer.sv
// ----------------------------------------------------------------------------
// controller_message_deframer
// Assembles received controller bytes into a message buffer by issuing
// buffer writes; plain, response and remote-ack framing.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while the result register can take
// it. Each byte gives one to three output transactions (a write, a CR LF pair
// on a full buffer, or a status-only transaction when nothing is stored); the
// output port moves one per clock while the receiver is ready, and the input
// stalls until all but the last result of a byte have left. A byte passes
// the input register, then the result register, before its first result
// appears. Configuration writes apply at once; a frame_mode change is seen
// at the next new_message, and reset returns to plain framing.
`default_nettype none

module controller_message_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] new_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [8:0] write_index, [16:9] write_byte,
                                             // [17] message_done, [18] dropped,
                                             // [27:19] text_length, rest zero
    output logic             m_axis_tuser,   // [0] write_valid
    output logic             m_axis_tlast    // last_of_run
);
    import cmd_pkg::*;

    localparam logic [2:0] REG_FRAME_MODE  = 3'd0;
    localparam logic [2:0] REG_END_FIRST   = 3'd1;
    localparam logic [2:0] REG_END_SECOND  = 3'd2;
    localparam logic [2:0] REG_BEGIN_MARK  = 3'd3;
    localparam logic [2:0] REG_ACK_TERM    = 3'd4;
    localparam logic [2:0] REG_SHOW_BAD_CR = 3'd5;
    localparam logic [2:0] REG_MAX_LEN     = 3'd6;

    cfg_t        cfg_reg;
    logic        can_load;
    logic        load;
    result_set_t res_set;
    result_t     head_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_mode     <= 2'd0;
            cfg_reg.end_first      <= 8'd13;
            cfg_reg.end_second     <= 8'd10;
            cfg_reg.begin_mark     <= 8'd27;
            cfg_reg.ack_terminator <= 8'd10;
            cfg_reg.show_bad_cr    <= 1'b0;
            cfg_reg.max_len        <= 9'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FRAME_MODE:  cfg_reg.frame_mode     <= cfg_wdata[1:0];
                REG_END_FIRST:   cfg_reg.end_first      <= cfg_wdata[7:0];
                REG_END_SECOND:  cfg_reg.end_second     <= cfg_wdata[7:0];
                REG_BEGIN_MARK:  cfg_reg.begin_mark     <= cfg_wdata[7:0];
                REG_ACK_TERM:    cfg_reg.ack_terminator <= cfg_wdata[7:0];
                REG_SHOW_BAD_CR: cfg_reg.show_bad_cr    <= cfg_wdata[0];
                REG_MAX_LEN:     cfg_reg.max_len        <= cfg_wdata;
                default:         cfg_reg.max_len        <= cfg_reg.max_len;
            endcase
        end
    end

    cmd_step u_step
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .can_load      (can_load),
        .load          (load),
        .res_set       (res_set)
    );

    cmd_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .res_set       (res_set),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .head_res      (head_res)
    );

    assign m_axis_tdata = {4'd0, head_res.text_length, head_res.dropped,
                           head_res.message_done, head_res.write_byte,
                           head_res.write_index};
    assign m_axis_tuser = head_res.write_valid;
    assign m_axis_tlast = head_res.last_of_run;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the controller message deframer. A directed table
// runs first and covers plain, response and remote-ack framing, unpaired end
// characters, the dot marker, forced finish on a full buffer and the limit
// extremes. Random phases follow, each with its own register setting, sending
// mostly well-formed messages with random content and some noise. Every write
// transaction is checked field by field against a local model of the framer.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cmd_pkg::*;

    localparam logic [2:0] REG_FRAME_MODE  = 3'd0;
    localparam logic [2:0] REG_END_FIRST   = 3'd1;
    localparam logic [2:0] REG_END_SECOND  = 3'd2;
    localparam logic [2:0] REG_BEGIN_MARK  = 3'd3;
    localparam logic [2:0] REG_ACK_TERM    = 3'd4;
    localparam logic [2:0] REG_SHOW_BAD_CR = 3'd5;
    localparam logic [2:0] REG_MAX_LEN     = 3'd6;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [7:0] CHAR_ESC   = 8'd27;
    localparam logic [7:0] CHAR_NUL   = 8'd0;

    localparam int RANDOM_ITEMS   = 220;
    localparam int PHASE_ITEMS    = 30;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0]
    {
        ST_TEXT,
        ST_WAIT_SECOND,
        ST_WAIT_FIRST,
        ST_HUNT,
        ST_RESP_TEXT,
        ST_RESP_END,
        ST_REMOTE,
        ST_DONE
    } frame_phase_t;

    typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

    typedef struct
    {
        row_kind_t  kind;
        logic [2:0] addr;
        logic [8:0] value;
        bit         typed;
        result_t    res;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire logic [31:0] m_axis_tdata;
    wire logic   m_axis_tuser;
    wire logic   m_axis_tlast;

    // framer model state
    cfg_t         cfg;
    frame_phase_t phase_q;
    int           wr_pos;
    int           head_count;
    logic [7:0]   head_bytes [3];
    bit           ok_err, begin_found, last_was_begin, nul_found, last_was_first_nul;
    bit           msg_done;
    result_t      step_results [$];
    result_t      pending_writes [$];

    int mismatches = 0;
    int checked = 0;
    int sent_items = 0;
    int idle_cycles = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    bit quiet_run = 1'b0;
    bit first_char = 1'b0;

    controller_message_deframer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Framer model
    // ------------------------------------------------------------------------
    function automatic void clear_frame();
        if (cfg.frame_mode == MODE_RESPONSE)
            phase_q = ST_HUNT;
        else if (cfg.frame_mode == MODE_REMOTE)
            phase_q = ST_REMOTE;
        else
            phase_q = ST_TEXT;
        wr_pos = 0;
        head_count = 0;
        head_bytes[0] = '0;
        head_bytes[1] = '0;
        head_bytes[2] = '0;
        ok_err = 1'b0;
        begin_found = 1'b0;
        last_was_begin = 1'b0;
        nul_found = 1'b0;
        last_was_first_nul = 1'b0;
        msg_done = 1'b0;
    endfunction

    function automatic void store_byte(int idx, logic [7:0] b, bit overwrite);
        result_t r;
        if (step_results.size() < 3)
        begin
            r = '0;
            r.write_valid = 1'b1;
            r.write_index = idx[8:0];
            r.write_byte = b;
            step_results.push_back(r);
        end
        if (idx < 3)
        begin
            head_bytes[idx] = b;
            if (head_count < idx + 1)
                head_count = idx + 1;
        end
        if (overwrite)
        begin
            if (last_was_first_nul)
                nul_found = 1'b0;
        end
        else if (last_was_begin)
            begin_found = 1'b1;
        last_was_begin = 1'b0;
        last_was_first_nul = 1'b0;
        if (!nul_found)
        begin
            if (b == CHAR_NUL)
            begin
                nul_found = 1'b1;
                last_was_first_nul = 1'b1;
            end
            else if (b == cfg.begin_mark)
                last_was_begin = 1'b1;
        end
        ok_err = (head_count >= 2 && head_bytes[0] == "o" && head_bytes[1] == "k") ||
                 (head_count >= 3 && head_bytes[0] == "e" && head_bytes[1] == "r" &&
                  head_bytes[2] == "r");
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic nm, output int n);
        int           lim;
        int           pos;
        int           prev;
        logic [7:0]   want;
        logic [7:0]   same;
        frame_phase_t back;
        bit           drop;
        bit           force_full;
        result_t      r;
        if (nm)
            clear_frame();
        lim = int'(cfg.max_len);
        if (lim < 1)
            lim = 1;
        if (lim > MAX_TEXT)
            lim = MAX_TEXT;
        step_results.delete();
        pos = wr_pos;
        prev = (pos != 0) ? pos - 1 : 0;
        drop = 1'b1;
        force_full = 1'b0;
        case (phase_q)
            ST_TEXT:
            begin
                if (b != CHAR_NUL)
                begin
                    if (b == cfg.end_first)
                        phase_q = ST_WAIT_SECOND;
                    else if (b == cfg.end_second)
                        phase_q = ST_WAIT_FIRST;
                    store_byte(pos, b, 1'b0);
                    pos++;
                    drop = 1'b0;
                end
            end
            ST_WAIT_SECOND, ST_WAIT_FIRST, ST_RESP_END:
            begin
                if (phase_q == ST_RESP_END || b != CHAR_NUL)
                begin
                    if (phase_q == ST_RESP_END)
                    begin
                        want = cfg.end_second;
                        same = cfg.end_first;
                        back = ST_RESP_TEXT;
                    end
                    else
                    begin
                        want = (phase_q == ST_WAIT_SECOND) ? cfg.end_second : cfg.end_first;
                        same = (phase_q == ST_WAIT_SECOND) ? cfg.end_first : cfg.end_second;
                        back = ST_TEXT;
                    end
                    if (b == want)
                    begin
                        store_byte(pos, b, 1'b0);
                        pos++;
                        drop = 1'b0;
                        // a response without ok/err and without a begin mark waits
                        if (phase_q == ST_RESP_END && !ok_err && cfg.begin_mark != CHAR_NUL &&
                            !begin_found && !last_was_begin)
                            phase_q = ST_RESP_TEXT;
                        else
                            phase_q = ST_DONE;
                    end
                    else
                    begin
                        if (b != same)
                            phase_q = back;
                        if (cfg.show_bad_cr)
                        begin
                            store_byte(prev, CHAR_DOT, 1'b1);
                            if (pos + 1 >= lim)
                                force_full = 1'b1;
                            else
                            begin
                                store_byte(pos, b, 1'b0);
                                pos++;
                                drop = 1'b0;
                            end
                        end
                        else
                        begin
                            store_byte(prev, b, 1'b1);
                            drop = 1'b0;
                        end
                    end
                end
            end
            ST_HUNT:
            begin
                if (b == cfg.begin_mark)
                    phase_q = ST_RESP_TEXT;
            end
            ST_RESP_TEXT:
            begin
                if (b == cfg.end_first)
                    phase_q = ST_RESP_END;
                store_byte(pos, b, 1'b0);
                pos++;
                drop = 1'b0;
            end
            ST_REMOTE:
            begin
                if (b == cfg.ack_terminator)
                    phase_q = ST_DONE;
                else
                begin
                    store_byte(pos, b, 1'b0);
                    pos++;
                    drop = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (phase_q != ST_DONE && (force_full || pos >= lim))
        begin
            store_byte(pos, CHAR_CR, 1'b0);
            store_byte(pos + 1, CHAR_LF, 1'b0);
            pos += 2;
            phase_q = ST_DONE;
        end
        wr_pos = pos & 'h1FF;
        msg_done = (phase_q == ST_DONE);
        if (step_results.size() == 0)
            step_results.push_back('0);
        n = step_results.size();
        for (int k = 0; k < n; k++)
        begin
            r = step_results[k];
            r.last_of_run = (k == n - 1);
            r.message_done = msg_done;
            r.dropped = drop;
            r.text_length = wr_pos[8:0];
            pending_writes.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic nm, bit typed, result_t typed_res);
        int n;
        while (!quiet_run && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= nm;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        deframe_byte(b, nm, n);
        if (typed)
            pending_writes[pending_writes.size() - n] = typed_res;
        sent_items++;
        @(negedge clk);
    endtask

    task automatic text_char(logic [7:0] c);
        send_byte(c, first_char, 1'b0, '0);
        first_char = 1'b0;
    endtask

    task automatic drain_writes();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [2:0] addr, logic [8:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        case (addr)
            REG_FRAME_MODE:  cfg.frame_mode = value[1:0];
            REG_END_FIRST:   cfg.end_first = value[7:0];
            REG_END_SECOND:  cfg.end_second = value[7:0];
            REG_BEGIN_MARK:  cfg.begin_mark = value[7:0];
            REG_ACK_TERM:    cfg.ack_terminator = value[7:0];
            REG_SHOW_BAD_CR: cfg.show_bad_cr = value[0];
            REG_MAX_LEN:     cfg.max_len = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_text();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == cfg.end_first || c == cfg.end_second || c == cfg.begin_mark ||
               c == cfg.ack_terminator);
        return c;
    endfunction

    task automatic send_body(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                text_char(CHAR_NUL);
            else if (r < 14)
                text_char($urandom_range(1) ? cfg.end_first : cfg.end_second);
            else if (r < 18)
                text_char(cfg.begin_mark);
            else
                text_char(pick_text());
        end
    endtask

    task automatic send_end_pair();
        if ($urandom_range(1))
        begin
            text_char(cfg.end_first);
            text_char(cfg.end_second);
        end
        else
        begin
            text_char(cfg.end_second);
            text_char(cfg.end_first);
        end
    endtask

    task automatic send_message();
        int k;
        first_char = 1'b1;
        if ($urandom_range(99) < 15)
        begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++)
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
        end
        else
        begin
            case (cfg.frame_mode)
                MODE_RESPONSE:
                begin
                    k = $urandom_range(0, 3);
                    for (int i = 0; i < k; i++)
                        text_char(pick_text());
                    text_char(cfg.begin_mark);
                    case ($urandom_range(2))
                        0:
                        begin
                            text_char("o");
                            text_char("k");
                        end
                        1:
                        begin
                            text_char("e");
                            text_char("r");
                            text_char("r");
                        end
                        default:
                        begin
                        end
                    endcase
                    send_body($urandom_range(0, 8));
                    text_char(cfg.end_first);
                    text_char(cfg.end_second);
                    if ($urandom_range(1))
                    begin
                        send_body($urandom_range(0, 4));
                        text_char(cfg.end_first);
                        text_char(cfg.end_second);
                    end
                end
                MODE_REMOTE:
                begin
                    send_body($urandom_range(0, 10));
                    if ($urandom_range(9) != 0)
                        text_char(cfg.ack_terminator);
                end
                default:
                begin
                    send_body($urandom_range(0, 10));
                    if ($urandom_range(9) != 0)
                        send_end_pair();
                end
            endcase
            if ($urandom_range(99) < 20)
            begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    text_char(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic randomise_setup(int phase_no);
        logic [1:0] md;
        logic [7:0] ef, es, bm, at;
        logic       bad;
        logic [8:0] len;
        int         r;
        md = 2'($urandom_range(3));
        bad = 1'($urandom_range(1));
        ef = ($urandom_range(9) < 7) ? CHAR_CR : 8'($urandom_range(255));
        es = ($urandom_range(9) < 7) ? CHAR_LF : 8'($urandom_range(255));
        at = ($urandom_range(9) < 7) ? CHAR_LF : 8'($urandom_range(255));
        r = $urandom_range(9);
        bm = (r < 2) ? CHAR_NUL : (r < 7) ? CHAR_ESC : 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 10)
            len = 9'd0;
        else if (r < 15)
            len = 9'h1FF;
        else if (r < 25)
            len = 9'd256;
        else if (r < 55)
            len = 9'($urandom_range(1, 8));
        else if (r < 75)
            len = 9'd255;
        else
            len = 9'($urandom_range(9, 255));
        if (phase_no == 1)
        begin
            ef = 8'h00;
            es = 8'h00;
            bm = 8'h00;
            at = 8'h00;
            len = 9'd0;
        end
        else if (phase_no == 3)
        begin
            ef = 8'hFF;
            es = 8'hFF;
            bm = 8'hFF;
            at = 8'hFF;
            len = 9'd256;
            bad = 1'b1;
        end
        cfg_write(REG_FRAME_MODE, {7'd0, md});
        cfg_write(REG_END_FIRST, {1'b0, ef});
        cfg_write(REG_END_SECOND, {1'b0, es});
        cfg_write(REG_BEGIN_MARK, {1'b0, bm});
        cfg_write(REG_ACK_TERM, {1'b0, at});
        cfg_write(REG_SHOW_BAD_CR, {8'd0, bad});
        cfg_write(REG_MAX_LEN, len);
    endtask

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic result_t write_of(logic v, logic [8:0] idx, logic [7:0] b,
                                         logic last, logic done, logic drop,
                                         logic [8:0] len);
        result_t r;
        r.write_valid = v;
        r.write_index = idx;
        r.write_byte = b;
        r.last_of_run = last;
        r.message_done = done;
        r.dropped = drop;
        r.text_length = len;
        return r;
    endfunction

    function automatic table_row_t cfg_row(logic [2:0] addr, logic [8:0] value);
        table_row_t r;
        r.kind = ROW_CFG;
        r.addr = addr;
        r.value = value;
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic table_row_t byte_row(logic nm, logic [7:0] b, bit typed, result_t res);
        table_row_t r;
        r.kind = ROW_BYTE;
        r.addr = '0;
        r.value = {nm, b};
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic note_error(string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
        if (got_v !== want_v)
            note_error($sformatf("transaction %0d %s: got %0h, expected %0h",
                                 checked, name, got_v, want_v));
    endtask

    always @(posedge clk)
    begin : check_writes
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_writes.size() == 0)
                note_error($sformatf("unexpected write transaction, tdata %0h", m_axis_tdata));
            else
            begin
                want = pending_writes.pop_front();
                check_field("write_valid", 32'(m_axis_tuser), 32'(want.write_valid));
                check_field("write_index", 32'(m_axis_tdata[8:0]), 32'(want.write_index));
                check_field("write_byte", 32'(m_axis_tdata[16:9]), 32'(want.write_byte));
                check_field("last_of_run", 32'(m_axis_tlast), 32'(want.last_of_run));
                check_field("message_done", 32'(m_axis_tdata[17]),
                            32'(want.message_done));
                check_field("dropped", 32'(m_axis_tdata[18]), 32'(want.dropped));
                check_field("text_length", 32'(m_axis_tdata[27:19]),
                            32'(want.text_length));
                check_field("tdata padding", 32'(m_axis_tdata[31:28]), 32'd0);
            end
            checked++;
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_served)
        begin
            m_axis_tready <= 1'b0;
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
        end
        else
            m_axis_tready <= quiet_run || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        table_row_t directed [$];
        table_row_t row;
        int         target;

        cfg.frame_mode = MODE_PLAIN;
        cfg.end_first = CHAR_CR;
        cfg.end_second = CHAR_LF;
        cfg.begin_mark = CHAR_ESC;
        cfg.ack_terminator = CHAR_LF;
        cfg.show_bad_cr = 1'b0;
        cfg.max_len = 9'd255;
        clear_frame();

        // plain framing, NUL skip, repeated and unpaired end characters
        directed.push_back(byte_row(1'b1, "h", 1'b1,
            write_of(1'b1, 9'd0, "h", 1'b1, 1'b0, 1'b0, 9'd1)));
        directed.push_back(byte_row(1'b0, CHAR_NUL, 1'b1,
            write_of(1'b0, 9'd0, 8'd0, 1'b1, 1'b0, 1'b1, 9'd1)));
        directed.push_back(byte_row(1'b0, CHAR_CR, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_CR, 1'b0, '0));
        directed.push_back(byte_row(1'b0, 8'hFF, 1'b1,
            write_of(1'b1, 9'd1, 8'hFF, 1'b1, 1'b0, 1'b0, 9'd2)));
        directed.push_back(byte_row(1'b0, CHAR_LF, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_CR, 1'b1,
            write_of(1'b1, 9'd3, CHAR_CR, 1'b1, 1'b1, 1'b0, 9'd4)));
        directed.push_back(byte_row(1'b0, "z", 1'b1,
            write_of(1'b0, 9'd0, 8'd0, 1'b1, 1'b1, 1'b1, 9'd4)));
        // dot marker that runs into a full buffer
        directed.push_back(cfg_row(REG_SHOW_BAD_CR, 9'd1));
        directed.push_back(cfg_row(REG_MAX_LEN, 9'd3));
        directed.push_back(byte_row(1'b1, "a", 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_CR, 1'b0, '0));
        directed.push_back(byte_row(1'b0, "q", 1'b0, '0));
        // zero limit acts as one
        directed.push_back(cfg_row(REG_SHOW_BAD_CR, 9'd0));
        directed.push_back(cfg_row(REG_MAX_LEN, 9'd0));
        directed.push_back(byte_row(1'b1, "a", 1'b1,
            write_of(1'b1, 9'd0, "a", 1'b0, 1'b1, 1'b0, 9'd3)));
        // response framing: ok prefix, then a reply that waits for a second one
        directed.push_back(cfg_row(REG_MAX_LEN, 9'h1FF));
        directed.push_back(cfg_row(REG_FRAME_MODE, {7'd0, MODE_RESPONSE}));
        directed.push_back(byte_row(1'b1, "j", 1'b1,
            write_of(1'b0, 9'd0, 8'd0, 1'b1, 1'b0, 1'b1, 9'd0)));
        directed.push_back(byte_row(1'b0, CHAR_ESC, 1'b0, '0));
        directed.push_back(byte_row(1'b0, "o", 1'b0, '0));
        directed.push_back(byte_row(1'b0, "k", 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_CR, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_LF, 1'b0, '0));
        directed.push_back(byte_row(1'b1, CHAR_ESC, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_CR, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_LF, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_ESC, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_CR, 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_LF, 1'b0, '0));
        // remote ack
        directed.push_back(cfg_row(REG_FRAME_MODE, {7'd0, MODE_REMOTE}));
        directed.push_back(byte_row(1'b1, "r", 1'b0, '0));
        directed.push_back(byte_row(1'b0, CHAR_LF, 1'b1,
            write_of(1'b0, 9'd0, 8'd0, 1'b1, 1'b1, 1'b1, 9'd1)));

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            if (row.kind == ROW_CFG)
            begin
                drain_writes();
                cfg_write(row.addr, row.value);
            end
            else
                send_byte(row.value[7:0], row.value[8], row.typed, row.res);
        end

        sent_items = 0;
        for (int phase_no = 0; sent_items < RANDOM_ITEMS; phase_no++)
        begin
            drain_writes();
            quiet_run = (phase_no == 2);
            randomise_setup(phase_no);
            if (phase_no == 4)
                hold_asked++;
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target)
                send_message();
        end

        drain_writes();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/cmd_pkg.sv
hw/rtl/cmd_step.sv
hw/rtl/cmd_out.sv
hw/rtl/controller_message_deframer.sv
tb/testbench.sv
